// ===== hdl/h3sp_pkg.sv =====
`timescale 1ns / 1ps

package h3sp_pkg;

    localparam int VALUE_W   = 62;
    localparam int SECTION_W = 64;
    localparam int COUNT_W   = 3;

    localparam logic [VALUE_W-1:0] ID_TABLE_CAPACITY = VALUE_W'(8'h01);
    localparam logic [VALUE_W-1:0] ID_RESERVED_LO    = VALUE_W'(8'h02);
    localparam logic [VALUE_W-1:0] ID_RESERVED_HI    = VALUE_W'(8'h05);
    localparam logic [VALUE_W-1:0] ID_SECTION_SIZE   = VALUE_W'(8'h06);
    localparam logic [VALUE_W-1:0] ID_BLOCKED        = VALUE_W'(8'h07);

    localparam logic [VALUE_W-1:0]   CAPACITY_DEFAULT = '0;
    localparam logic [SECTION_W-1:0] SECTION_DEFAULT  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [VALUE_W-1:0]   BLOCKED_DEFAULT  = '0;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TRUNC    = 2'd1,
        STATUS_RESERVED = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_item_t;

    typedef struct packed {
        status_t                status;
        logic [VALUE_W-1:0]     capacity;
        logic [SECTION_W-1:0]   section_size;
        logic [VALUE_W-1:0]     blocked;
    } result_t;

endpackage

// ===== hdl/h3sp_in_stage.sv =====
`timescale 1ns / 1ps

module h3sp_in_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           payload_byte,
    input  logic                 last_byte,
    input  logic                 advance,
    output logic                 item_valid,
    output h3sp_pkg::byte_item_t item
);

    logic                 valid_reg;
    logic                 valid_next;
    h3sp_pkg::byte_item_t item_reg;
    logic                 accept;

    assign in_stall   = valid_reg && !advance;
    assign accept     = in_valid && !in_stall;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.data <= payload_byte;
            item_reg.last <= last_byte;
        end
    end

endmodule

// ===== hdl/h3sp_decoder.sv =====
`timescale 1ns / 1ps

module h3sp_decoder
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  h3sp_pkg::byte_item_t item,
    output h3sp_pkg::result_t    result
);

    localparam int VW = h3sp_pkg::VALUE_W;
    localparam int SW = h3sp_pkg::SECTION_W;
    localparam int CW = h3sp_pkg::COUNT_W;

    logic                want_value_reg, want_value_next;
    logic [CW-1:0]       bytes_left_reg, bytes_left_next;
    logic [VW-1:0]       acc_reg, acc_next;
    logic [VW-1:0]       held_id_reg, held_id_next;
    logic [VW-1:0]       capacity_reg, capacity_next;
    logic [SW-1:0]       section_reg, section_next;
    logic [VW-1:0]       blocked_reg, blocked_next;
    h3sp_pkg::status_t   error_reg, error_next;
    h3sp_pkg::status_t   status;

    always_comb
    begin
        want_value_next = want_value_reg;
        bytes_left_next = bytes_left_reg;
        acc_next        = acc_reg;
        held_id_next    = held_id_reg;
        capacity_next   = capacity_reg;
        section_next    = section_reg;
        blocked_next    = blocked_reg;
        error_next      = error_reg;

        if (error_reg == h3sp_pkg::STATUS_OK)
        begin
            if (bytes_left_reg == '0)
            begin
                acc_next = VW'(item.data[5:0]);
                unique case (item.data[7:6])
                    2'd0: bytes_left_next = CW'(0);
                    2'd1: bytes_left_next = CW'(1);
                    2'd2: bytes_left_next = CW'(3);
                    2'd3: bytes_left_next = CW'(7);
                    default: bytes_left_next = CW'(0);
                endcase
            end
            else
            begin
                acc_next        = {acc_reg[VW-9:0], item.data};
                bytes_left_next = bytes_left_reg - CW'(1);
            end

            if (bytes_left_next == '0)
            begin
                if (!want_value_reg)
                begin
                    held_id_next    = acc_next;
                    want_value_next = 1'b1;
                end
                else
                begin
                    want_value_next = 1'b0;
                    priority if (held_id_reg == h3sp_pkg::ID_TABLE_CAPACITY)
                    begin
                        capacity_next = acc_next;
                    end
                    else if (held_id_reg == h3sp_pkg::ID_SECTION_SIZE)
                    begin
                        section_next = SW'(acc_next);
                    end
                    else if (held_id_reg == h3sp_pkg::ID_BLOCKED)
                    begin
                        blocked_next = acc_next;
                    end
                    else if (held_id_reg >= h3sp_pkg::ID_RESERVED_LO &&
                             held_id_reg <= h3sp_pkg::ID_RESERVED_HI)
                    begin
                        error_next = h3sp_pkg::STATUS_RESERVED;
                    end
                    else
                    begin
                        error_next = error_reg;
                    end
                end
            end
        end

        if (error_next == h3sp_pkg::STATUS_OK &&
            (bytes_left_next != '0 || want_value_next))
        begin
            status = h3sp_pkg::STATUS_TRUNC;
        end
        else
        begin
            status = error_next;
        end
    end

    assign result.status       = status;
    assign result.capacity     = capacity_next;
    assign result.section_size = section_next;
    assign result.blocked      = blocked_next;

    // Return to defaults after the last byte of a payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            want_value_reg <= 1'b0;
            bytes_left_reg <= '0;
            acc_reg        <= '0;
            held_id_reg    <= '0;
            capacity_reg   <= h3sp_pkg::CAPACITY_DEFAULT;
            section_reg    <= h3sp_pkg::SECTION_DEFAULT;
            blocked_reg    <= h3sp_pkg::BLOCKED_DEFAULT;
            error_reg      <= h3sp_pkg::STATUS_OK;
        end
        else if (take)
        begin
            if (item.last)
            begin
                want_value_reg <= 1'b0;
                bytes_left_reg <= '0;
                acc_reg        <= '0;
                held_id_reg    <= '0;
                capacity_reg   <= h3sp_pkg::CAPACITY_DEFAULT;
                section_reg    <= h3sp_pkg::SECTION_DEFAULT;
                blocked_reg    <= h3sp_pkg::BLOCKED_DEFAULT;
                error_reg      <= h3sp_pkg::STATUS_OK;
            end
            else
            begin
                want_value_reg <= want_value_next;
                bytes_left_reg <= bytes_left_next;
                acc_reg        <= acc_next;
                held_id_reg    <= held_id_next;
                capacity_reg   <= capacity_next;
                section_reg    <= section_next;
                blocked_reg    <= blocked_next;
                error_reg      <= error_next;
            end
        end
    end

endmodule

// ===== hdl/h3sp_out_stage.sv =====
`timescale 1ns / 1ps

module h3sp_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  h3sp_pkg::result_t result,
    output logic              ready,
    output logic              out_valid,
    input  logic              out_stall,
    output h3sp_pkg::result_t held
);

    logic              valid_reg;
    logic              valid_next;
    h3sp_pkg::result_t result_reg;

    assign ready     = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign held      = result_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

endmodule

// ===== hdl/h3_settings_payload_parser_top.sv =====
`timescale 1ns / 1ps
// Path: a last byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle; the decode state updates as a byte passes
// between the input register and the result register. A last byte waits in the
// input register only while the previous result is still stalled at the output.
// Reset: asynchronous, active low; clears the valid flags of both registers and returns the
// settings to their defaults (capacity 0, section size all ones, blocked 0).

module h3_settings_payload_parser_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  payload_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [61:0] table_capacity,
    output logic [63:0] field_section_size,
    output logic [61:0] blocked_streams
);

    logic                 item_valid;
    h3sp_pkg::byte_item_t item;
    logic                 advance;
    logic                 out_ready;
    h3sp_pkg::result_t    result;
    h3sp_pkg::result_t    held;

    // Advance a byte unless it ends a payload and the result slot is busy.
    assign advance = item_valid && (!item.last || out_ready);

    h3sp_in_stage u_in_stage
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .payload_byte (payload_byte),
        .last_byte    (last_byte),
        .advance      (advance),
        .item_valid   (item_valid),
        .item         (item)
    );

    h3sp_decoder u_decoder
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (advance),
        .item   (item),
        .result (result)
    );

    h3sp_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && item.last),
        .result    (result),
        .ready     (out_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .held      (held)
    );

    assign status             = held.status;
    assign table_capacity     = held.capacity;
    assign field_section_size = held.section_size;
    assign blocked_streams    = held.blocked;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam logic [1:0] LEN1 = 2'd0;
    localparam logic [1:0] LEN2 = 2'd1;
    localparam logic [1:0] LEN4 = 2'd2;
    localparam logic [1:0] LEN8 = 2'd3;
    localparam int IDLE_PCT = 21;
    localparam int RANDOM_ITEMS = 1550;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  payload_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [61:0] table_capacity;
    logic [63:0] field_section_size;
    logic [61:0] blocked_streams;

    h3_settings_payload_parser_top dut
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .payload_byte       (payload_byte),
        .last_byte          (last_byte),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .status             (status),
        .table_capacity     (table_capacity),
        .field_section_size (field_section_size),
        .blocked_streams    (blocked_streams)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    h3sp_pkg::byte_item_t  pending_bytes[$];
    logic [7:0]            frame_bytes[$];
    h3sp_pkg::result_t     expected_results[$];

    int errors = 0;
    int bytes_accepted = 0;
    int frames_built = 0;
    int results_checked = 0;
    int seen_ok = 0;
    int seen_trunc = 0;
    int seen_reserved = 0;
    logic calm;

    assign calm = (bytes_accepted >= 600) && (bytes_accepted < 950);

    // decoder mirror
    logic                want_val = 1'b0;
    logic [2:0]          bytes_rem = '0;
    logic [61:0]         acc = '0;
    logic [61:0]         held_id = '0;
    logic [61:0]         cap_q = h3sp_pkg::CAPACITY_DEFAULT;
    logic [63:0]         sect_q = h3sp_pkg::SECTION_DEFAULT;
    logic [61:0]         blk_q = h3sp_pkg::BLOCKED_DEFAULT;
    h3sp_pkg::status_t   err_q = h3sp_pkg::STATUS_OK;

    task automatic clear_decoder();
        want_val = 1'b0;
        bytes_rem = '0;
        acc = '0;
        held_id = '0;
        cap_q = h3sp_pkg::CAPACITY_DEFAULT;
        sect_q = h3sp_pkg::SECTION_DEFAULT;
        blk_q = h3sp_pkg::BLOCKED_DEFAULT;
        err_q = h3sp_pkg::STATUS_OK;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic last);
        h3sp_pkg::result_t r;
        if (err_q == h3sp_pkg::STATUS_OK)
        begin
            if (bytes_rem == 3'd0)
            begin
                acc = {56'd0, b[5:0]};
                case (b[7:6])
                    LEN1: bytes_rem = 3'd0;
                    LEN2: bytes_rem = 3'd1;
                    LEN4: bytes_rem = 3'd3;
                    default: bytes_rem = 3'd7;
                endcase
            end
            else
            begin
                acc = {acc[53:0], b};
                bytes_rem = bytes_rem - 3'd1;
            end
            if (bytes_rem == 3'd0)
            begin
                if (!want_val)
                begin
                    held_id = acc;
                    want_val = 1'b1;
                end
                else
                begin
                    want_val = 1'b0;
                    if (held_id == h3sp_pkg::ID_TABLE_CAPACITY)
                        cap_q = acc;
                    else if (held_id == h3sp_pkg::ID_SECTION_SIZE)
                        sect_q = {2'b00, acc};
                    else if (held_id == h3sp_pkg::ID_BLOCKED)
                        blk_q = acc;
                    else if (held_id >= h3sp_pkg::ID_RESERVED_LO &&
                             held_id <= h3sp_pkg::ID_RESERVED_HI)
                        err_q = h3sp_pkg::STATUS_RESERVED;
                end
            end
        end
        if (last)
        begin
            r.status = err_q;
            if (err_q == h3sp_pkg::STATUS_OK && (bytes_rem != 3'd0 || want_val))
                r.status = h3sp_pkg::STATUS_TRUNC;
            r.capacity = cap_q;
            r.section_size = sect_q;
            r.blocked = blk_q;
            expected_results.push_back(r);
            clear_decoder();
        end
    endtask

    function automatic logic [61:0] pick_value(input logic [1:0] len);
        logic [61:0] v;
        int bits;
        bits = 8 * (1 << len) - 2;
        case ($urandom_range(9))
            0: v = '0;
            1: v = '1;
            default: v = 62'({$urandom, $urandom});
        endcase
        return v & ((62'd1 << bits) - 62'd1);
    endfunction

    task automatic add_varint(input logic [61:0] v, input logic [1:0] len);
        logic [63:0] w;
        int bits;
        int n;
        bits = 8 * (1 << len) - 2;
        n = 1 << len;
        w = 64'(v & ((62'd1 << bits) - 62'd1)) | (64'(len) << bits);
        for (int i = n - 1; i >= 0; i--)
            frame_bytes.push_back(w[8*i +: 8]);
    endtask

    task automatic send_frame();
        h3sp_pkg::byte_item_t it;
        for (int i = 0; i < frame_bytes.size(); i++)
        begin
            it.data = frame_bytes[i];
            it.last = (i == frame_bytes.size() - 1);
            pending_bytes.push_back(it);
        end
        frame_bytes.delete();
        frames_built++;
    endtask

    function automatic logic [1:0] pick_len();
        if ($urandom_range(99) < 60)
            return LEN1;
        return 2'($urandom_range(3));
    endfunction

    task automatic random_frame();
        int r;
        int k;
        int keep;
        int pairs;
        logic [61:0] id;
        logic [1:0] vlen;
        r = $urandom_range(99);
        if (r < 6)
        begin
            k = $urandom_range(12, 1);
            repeat (k)
                frame_bytes.push_back(8'($urandom));
        end
        else
        begin
            pairs = $urandom_range(4, 1);
            repeat (pairs)
            begin
                k = $urandom_range(99);
                if (k < 25)
                    id = h3sp_pkg::ID_TABLE_CAPACITY;
                else if (k < 50)
                    id = h3sp_pkg::ID_SECTION_SIZE;
                else if (k < 75)
                    id = h3sp_pkg::ID_BLOCKED;
                else if (k < 83)
                    id = h3sp_pkg::ID_RESERVED_LO + 62'($urandom_range(3));
                else
                    id = '0;
                if (k >= 83)
                begin
                    vlen = 2'($urandom_range(3));
                    id = pick_value(vlen);
                    add_varint(id, vlen);
                end
                else
                    add_varint(id, pick_len());
                vlen = 2'($urandom_range(3));
                add_varint(pick_value(vlen), vlen);
            end
            if (r < 18 && frame_bytes.size() > 1)
            begin
                // cut the payload short at a random byte
                keep = $urandom_range(frame_bytes.size() - 1, 1);
                while (frame_bytes.size() > keep)
                    void'(frame_bytes.pop_back());
            end
            else if (r < 24)
                add_varint(h3sp_pkg::ID_BLOCKED, pick_len());
        end
        send_frame();
    endtask

    // driver
    always @(posedge clk)
    begin : drive
        h3sp_pkg::byte_item_t nxt;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                decode_byte(payload_byte, last_byte);
                bytes_accepted++;
            end
            if (in_valid && in_stall)
            begin
                // hold
            end
            else if (pending_bytes.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                nxt = pending_bytes.pop_front();
                in_valid <= 1'b1;
                payload_byte <= nxt.data;
                last_byte <= nxt.last;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin : watch
        h3sp_pkg::result_t exp_r;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: status %0d", status);
                    errors++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    results_checked++;
                    if (status != exp_r.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_r.status, status);
                        errors++;
                    end
                    if (table_capacity != exp_r.capacity)
                    begin
                        $error("table_capacity: expected %h, got %h",
                               exp_r.capacity, table_capacity);
                        errors++;
                    end
                    if (field_section_size != exp_r.section_size)
                    begin
                        $error("field_section_size: expected %h, got %h",
                               exp_r.section_size, field_section_size);
                        errors++;
                    end
                    if (blocked_streams != exp_r.blocked)
                    begin
                        $error("blocked_streams: expected %h, got %h",
                               exp_r.blocked, blocked_streams);
                        errors++;
                    end
                    case (exp_r.status)
                        h3sp_pkg::STATUS_OK: seen_ok++;
                        h3sp_pkg::STATUS_TRUNC: seen_trunc++;
                        default: seen_reserved++;
                    endcase
                end
            end
            out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    initial
    begin
        // single identifier byte, no value
        add_varint(62'd0, LEN1);
        send_frame();
        add_varint(h3sp_pkg::ID_TABLE_CAPACITY, LEN1);
        add_varint(62'h3F, LEN1);
        send_frame();
        // widest value
        add_varint(h3sp_pkg::ID_SECTION_SIZE, LEN1);
        add_varint('1, LEN8);
        send_frame();
        add_varint(h3sp_pkg::ID_BLOCKED, LEN1);
        add_varint(62'h3FFF, LEN2);
        send_frame();
        add_varint(h3sp_pkg::ID_RESERVED_LO, LEN1);
        add_varint(62'd0, LEN1);
        send_frame();
        // reserved identifier whose value is cut off
        add_varint(h3sp_pkg::ID_RESERVED_HI, LEN1);
        frame_bytes.push_back({LEN2, 6'd0});
        send_frame();
        // bytes after an error are dropped
        add_varint(h3sp_pkg::ID_RESERVED_LO + 62'd1, LEN1);
        add_varint(62'd0, LEN1);
        add_varint(h3sp_pkg::ID_BLOCKED, LEN1);
        send_frame();
        // a setting before the error still shows
        add_varint(h3sp_pkg::ID_TABLE_CAPACITY, LEN1);
        add_varint(62'd5, LEN1);
        add_varint(h3sp_pkg::ID_RESERVED_HI - 62'd1, LEN1);
        add_varint(62'd0, LEN1);
        send_frame();
        // unknown identifier is skipped
        add_varint(62'h3F, LEN1);
        add_varint(62'd0, LEN1);
        send_frame();
        while (pending_bytes.size() < RANDOM_ITEMS + 28)
            random_frame();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d bytes in %0d payloads; checked %0d results", bytes_accepted,
                 frames_built, results_checked);
        $display("Status mix: ok %0d, truncated %0d, reserved %0d", seen_ok, seen_trunc,
                 seen_reserved);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", expected_results.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
